// ===== rtl/core/sorted_priority_queue_macros.svh =====
// assertion macros for the sorted priority queue
// used by the top level only, no other dependencies
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
// shared constants, codes and types for the sorted priority queue
// no dependencies
package spq_pkg;

  localparam int unsigned VALUE_WIDTH     = 8;
  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned PRIO_WIDTH_DEF  = 16;
  localparam int unsigned STATUS_WIDTH    = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

  // sequencer status toward the output stage
  typedef struct packed {
    logic                    busy;
    logic                    res_valid;
    logic [VALUE_WIDTH-1:0]  removed_value;
    logic [STATUS_WIDTH-1:0] status;
    logic [VALUE_WIDTH-1:0]  head_value;
    logic                    head_valid;
  } ctrl_status_t;

endpackage

// ===== rtl/core/spq_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module spq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/spq_ctrl.sv =====
// sequencer of the sorted priority queue: circular list in ram, insert by tail scan
// depends on spq_pkg and spq_ram
module spq_ctrl #(
  parameter int unsigned Depth     = spq_pkg::DEPTH_DEF,
  parameter int unsigned PrioWidth = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  input  logic                                operation_i,
  input  logic [spq_pkg::VALUE_WIDTH-1:0]     item_value_i,
  input  logic signed [PrioWidth-1:0]         item_priority_i,
  input  logic                                res_take_i,
  output spq_pkg::ctrl_status_t               stat_o,
  output logic [$clog2(Depth+1)-1:0]          count_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned VW = spq_pkg::VALUE_WIDTH;
  localparam int unsigned EW = VW + PrioWidth;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(Depth - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [CW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(l);
    if (s >= (AW+1)'(Depth)) begin
      s = s - (AW+1)'(Depth);
    end
    ptr_add = s[AW-1:0];
  endfunction

  logic [2:0]                        state_q, state_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [AW-1:0]                     head_q, head_d;
  logic [AW-1:0]                     wp_q, wp_d;
  logic [CW-1:0]                     pos_q, pos_d;
  logic [VW-1:0]                     head_val_q, head_val_d;
  logic [VW-1:0]                     val_q, val_d;
  logic signed [PrioWidth-1:0]       key_q, key_d;
  logic [VW-1:0]                     removed_q, removed_d;
  logic [spq_pkg::STATUS_WIDTH-1:0]  status_q, status_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  logic [AW-1:0] tail;
  logic signed [PrioWidth-1:0] rd_prio;

  assign tail    = ptr_add(head_q, count_q);
  assign rd_prio = $signed(ram_rdata[PrioWidth-1:0]);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    wp_d       = wp_q;
    pos_d      = pos_q;
    head_val_d = head_val_q;
    val_d      = val_q;
    key_d      = key_q;
    removed_d  = removed_q;
    status_d   = status_q;
    ram_we     = 1'b0;
    ram_waddr  = wp_q;
    ram_wdata  = {val_q, key_q};
    ram_re     = 1'b0;
    ram_raddr  = ptr_dec(wp_q);
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          val_d     = item_value_i;
          key_d     = item_priority_i;
          removed_d = '0;
          status_d  = spq_pkg::ST_OK;
          state_d   = S_RESP;
          if (operation_i == spq_pkg::OP_ENQ) begin
            if (count_q == CW'(Depth)) begin
              status_d = spq_pkg::ST_FULL;
            end else if (count_q == '0) begin
              ram_we     = 1'b1;
              ram_waddr  = head_q;
              ram_wdata  = {item_value_i, item_priority_i};
              head_val_d = item_value_i;
              count_d    = count_q + CW'(1);
            end else begin
              // walk down from the tail, one entry per cycle
              wp_d      = tail;
              pos_d     = count_q;
              ram_re    = 1'b1;
              ram_raddr = ptr_dec(tail);
              state_d   = S_SCAN;
            end
          end else begin
            if (count_q == '0) begin
              status_d = spq_pkg::ST_EMPTY;
            end else begin
              removed_d = head_val_q;
              head_d    = ptr_inc(head_q);
              count_d   = count_q - CW'(1);
              if (count_q > CW'(1)) begin
                ram_re    = 1'b1;
                ram_raddr = ptr_inc(head_q);
                state_d   = S_HEAD;
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_prio > key_q) begin
          // move the larger entry up one slot
          ram_we    = 1'b1;
          ram_waddr = wp_q;
          ram_wdata = ram_rdata;
          wp_d      = ptr_dec(wp_q);
          pos_d     = pos_q - CW'(1);
          if (pos_q == CW'(1)) begin
            state_d = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_dec(ptr_dec(wp_q));
          end
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + CW'(1);
          state_d = S_RESP;
        end
      end
      S_PLACE: begin
        // new entry becomes the head
        ram_we     = 1'b1;
        head_val_d = val_q;
        count_d    = count_q + CW'(1);
        state_d    = S_RESP;
      end
      S_HEAD: begin
        head_val_d = ram_rdata[EW-1:PrioWidth];
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      head_q  <= head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wp_q       <= wp_d;
    pos_q      <= pos_d;
    head_val_q <= head_val_d;
    val_q      <= val_d;
    key_q      <= key_d;
    removed_q  <= removed_d;
    status_q   <= status_d;
  end

  spq_ram #(
    .Width (EW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign stat_o.busy          = (state_q != S_IDLE);
  assign stat_o.res_valid     = (state_q == S_RESP);
  assign stat_o.removed_value = removed_q;
  assign stat_o.status        = status_q;
  assign stat_o.head_valid    = (count_q != '0);
  assign stat_o.head_value    = (count_q != '0) ? head_val_q : '0;
  assign count_o              = count_q;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// sorted priority queue: enqueue on an empty or full queue goes straight to the response; else
// the sequencer scans from the tail through the entry ram (one entry a cycle), then responds
// dequeue responds directly, or after one ram read for the new head when entries remain
// one request at a time; result sits in an output register so the next request can enter
// reset empties the queue at once, ram contents need no clearing
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
  parameter int unsigned Depth     = spq_pkg::DEPTH_DEF,
  parameter int unsigned PrioWidth = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic [spq_pkg::VALUE_WIDTH-1:0]      item_value_i,
  input  logic signed [PrioWidth-1:0]          item_priority_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [spq_pkg::VALUE_WIDTH-1:0]      removed_value_o,
  output logic [spq_pkg::STATUS_WIDTH-1:0]     status_o,
  output logic [$clog2(Depth+1)-1:0]           entry_count_o,
  output logic [spq_pkg::VALUE_WIDTH-1:0]      head_value_o,
  output logic                                 head_valid_o
);

  localparam int unsigned CW = $clog2(Depth + 1);

  spq_pkg::ctrl_status_t stat;
  logic [CW-1:0]         count;
  logic                  res_take;

  logic                                 out_valid_q, out_valid_d;
  logic [spq_pkg::VALUE_WIDTH-1:0]      removed_q;
  logic [spq_pkg::STATUS_WIDTH-1:0]     status_q;
  logic [CW-1:0]                        count_q;
  logic [spq_pkg::VALUE_WIDTH-1:0]      head_value_q;
  logic                                 head_valid_q;

  assign in_stall_o = stat.busy;
  // output register free, or being emptied this cycle
  assign res_take   = stat.res_valid && (!out_valid_q || !out_stall_i);

  spq_ctrl #(
    .Depth     (Depth),
    .PrioWidth (PrioWidth)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (in_valid_i),
    .operation_i     (operation_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .res_take_i      (res_take),
    .stat_o          (stat),
    .count_o         (count)
  );

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      removed_q    <= stat.removed_value;
      status_q     <= stat.status;
      count_q      <= count;
      head_value_q <= stat.head_value;
      head_valid_q <= stat.head_valid;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign entry_count_o   = count_q;
  assign head_value_o    = head_value_q;
  assign head_valid_o    = head_valid_q;

  `SPQ_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request not followed by busy")
  `SPQ_ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count <= CW'(Depth), "entry count above depth")
  `SPQ_ASSERT_IMPLIES(a_full_reject, clk_i, rst_ni, out_valid_o && status_o == spq_pkg::ST_FULL, entry_count_o == CW'(Depth) && removed_value_o == '0, "full reject with bad count or value")
  `SPQ_ASSERT_IMPLIES(a_head_flag, clk_i, rst_ni, out_valid_o, head_valid_o == (entry_count_o != '0), "head flag disagrees with count")

endmodule
